// File: rtl/si2d_pkg.sv
package si2d_pkg;

  localparam int unsigned SigW = 64;
  localparam int unsigned ExpW = 13;
  localparam int unsigned BitsW = 63;
  localparam int unsigned TopW = 6;

  localparam logic [62:0] InfPattern = 63'h7FF0000000000000;

  typedef struct packed {
    logic [SigW-1:0] significand;
    logic below_nonzero;
    logic signed [ExpW-1:0] power_of_two;
  } si2d_req_t;

  typedef struct packed {
    logic [BitsW-1:0] double_bits;
    logic range_flag;
  } si2d_res_t;

endpackage

// File: rtl/si2d_round.sv
module si2d_round (
  input  si2d_pkg::si2d_req_t req_i,
  output si2d_pkg::si2d_res_t res_o
);
  import si2d_pkg::*;

  logic [TopW-1:0] top;
  logic signed [14:0] p;
  logic signed [14:0] biased;
  logic signed [14:0] t;
  logic [6:0] shl;
  logic [6:0] shr;
  logic [63:0] q;
  logic [63:0] lowmask;
  logic sticky;
  logic [53:0] m;
  logic [11:0] bexp;
  logic rnd;

  always_comb begin
    top = '0;
    for (int i = 0; i < 64; i++) begin
      if (req_i.significand[i]) begin
        top = TopW'(i);
      end
    end
  end

  always_comb begin
    p = 15'(top) + 15'(req_i.power_of_two);
    biased = p + 15'sd1023;
    t = 15'(req_i.power_of_two) + 15'sd1075;
    res_o = '0;
    shl = '0;
    shr = '0;
    q = '0;
    lowmask = '0;
    sticky = req_i.below_nonzero;
    m = '0;
    bexp = '0;
    rnd = 1'b0;
    if (req_i.significand == '0) begin
      res_o = '0;
    end else if (p > 15'sd1024 || biased >= 15'sd2047) begin
      res_o.double_bits = InfPattern;
      res_o.range_flag = 1'b1;
    end else if (p < -15'sd1076) begin
      res_o.range_flag = 1'b1;
    end else if (biased >= 15'sd1) begin
      if (top <= TopW'(53)) begin
        shl = 7'(6'd53 - top);
      end else begin
        shr = 7'(top - 6'd53);
      end
      lowmask = ~(64'hFFFF_FFFF_FFFF_FFFF << shr);
      sticky = sticky | ((req_i.significand & lowmask) != '0);
      q = (req_i.significand << shl) >> shr;
      rnd = q[0] & (sticky | q[1]);
      m = {1'b0, q[53:1]} + 54'(rnd);
      bexp = biased[11:0];
      if (m[53]) begin
        m = m >> 1;
        bexp = bexp + 12'd1;
      end
      if (bexp >= 12'd2047) begin
        res_o.double_bits = InfPattern;
        res_o.range_flag = 1'b1;
      end else begin
        res_o.double_bits = {bexp[10:0], m[51:0]};
      end
    end else begin
      if (t >= 15'sd0) begin
        shl = t[6:0];
        q = req_i.significand << shl;
      end else if (-t >= 15'sd64) begin
        sticky = 1'b1;
      end else begin
        shr = 7'(-t);
        lowmask = ~(64'hFFFF_FFFF_FFFF_FFFF << shr);
        sticky = sticky | ((req_i.significand & lowmask) != '0);
        q = req_i.significand >> shr;
      end
      rnd = q[0] & (sticky | q[1]);
      m = {1'b0, q[53:1]} + 54'(rnd);
      res_o.double_bits = 63'(m);
      res_o.range_flag = (q[0] | sticky) & ~m[52];
    end
  end

endmodule

// File: rtl/scaled_integer_to_binary64_core.sv
// Converts a 64-bit significand, sticky bit and signed power of two to the
// nearest positive binary64 (ties to even). One request per cycle unless
// back-pressure fills the skid slot: an input register feeds the leading-one
// search, shifter and rounder, whose result lands in an output register with a skid slot.
module scaled_integer_to_binary64_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [63:0] significand, [64] below_nonzero, [77:65] power_of_two
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [62:0] double_bits, [63] range_flag
  output logic [63:0] m_axis_tdata
);
  import si2d_pkg::*;

  si2d_req_t req_q;
  logic in_v_q;
  si2d_res_t res_d;
  si2d_res_t out_q, skid_q;
  logic out_v_q, skid_v_q;
  logic adv;

  assign s_axis_tready = ~skid_v_q;
  assign adv = ~skid_v_q;

  si2d_round u_round (.req_i(req_q), .res_o(res_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
      out_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (adv) begin
        in_v_q <= s_axis_tvalid;
      end
      if (!out_v_q || m_axis_tready) begin
        out_v_q <= skid_v_q | (adv & in_v_q);
        skid_v_q <= 1'b0;
      end else if (adv && in_v_q) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s_axis_tvalid) begin
      req_q <= {s_axis_tdata[63:0], s_axis_tdata[64], s_axis_tdata[77:65]};
    end
    if (!out_v_q || m_axis_tready) begin
      out_q <= skid_v_q ? skid_q : res_d;
    end else if (adv && in_v_q) begin
      skid_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = {out_q.range_flag, out_q.double_bits};

`ifndef ASSERT_OFF
  a_skid_only_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q) else $error("skid full with empty output");
  a_no_accept_when_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> !s_axis_tready) else $error("accept while skid full");
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !m_axis_tready)) else $error("bad skid fill");
`endif

endmodule
